// ===== hdl/kit_pkg.sv =====
// kit_pkg: shared types, constants and the keyword match for the keyword tokenizer
// used by kit_front, kit_fifo, kit_back and keyword_identifier_tokenizer
// no dependencies
package kit_pkg;

  localparam int ROW_BITS    = 16;
  localparam int COL_BITS    = 12;
  localparam int OFFSET_BITS = 24;
  localparam int LENGTH_BITS = 12;
  localparam int KIND_BITS   = 6;

  localparam int WORD_DEPTH  = 8;
  localparam int WORD_IDX    = $clog2(WORD_DEPTH);
  localparam int NUM_KW      = 32;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR    = $clog2(FIFO_DEPTH);

  localparam logic [KIND_BITS-1:0] KIND_EOF      = KIND_BITS'(0);
  localparam logic [KIND_BITS-1:0] KIND_ERROR    = KIND_BITS'(1);
  localparam logic [KIND_BITS-1:0] KIND_IDENT    = KIND_BITS'(2);
  localparam logic [KIND_BITS-1:0] KIND_FIRST_KW = KIND_BITS'(3);

  localparam logic [7:0] CHAR_NEWLINE    = 8'h0a;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;

  typedef struct packed {
    logic       end_of_input;
    logic [7:0] char_code;
  } kit_in_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]   token_kind;
    logic [ROW_BITS-1:0]    token_row;
    logic [COL_BITS-1:0]    token_col;
    logic [OFFSET_BITS-1:0] token_offset;
    logic [LENGTH_BITS-1:0] token_length;
    logic                   last_of_run;
  } kit_tok_t;

  // one queue entry: an optional word token and an optional eof/error token
  typedef struct packed {
    logic                    has_word;
    logic [WORD_DEPTH*8-1:0] word_chars;
    logic [LENGTH_BITS-1:0]  word_len;
    logic [ROW_BITS-1:0]     word_row;
    logic [COL_BITS-1:0]     word_col;
    logic [OFFSET_BITS-1:0]  word_off;
    logic                    has_tok2;
    logic                    tok2_err;
    logic [ROW_BITS-1:0]     tok2_row;
    logic [COL_BITS-1:0]     tok2_col;
    logic [OFFSET_BITS-1:0]  tok2_off;
  } kit_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } kit_fifo_stat_t;

  // keyword text, right aligned: first character in the highest used byte
  function automatic logic [WORD_DEPTH*8-1:0] kw_text(input int k);
    logic [WORD_DEPTH*8-1:0] t;
    t = '0;
    case (k)
      0:  t = "auto";
      1:  t = "double";
      2:  t = "int";
      3:  t = "struct";
      4:  t = "break";
      5:  t = "else";
      6:  t = "long";
      7:  t = "switch";
      8:  t = "case";
      9:  t = "enum";
      10: t = "register";
      11: t = "typedef";
      12: t = "char";
      13: t = "extern";
      14: t = "return";
      15: t = "union";
      16: t = "const";
      17: t = "float";
      18: t = "short";
      19: t = "unsigned";
      20: t = "continue";
      21: t = "for";
      22: t = "signed";
      23: t = "void";
      24: t = "default";
      25: t = "goto";
      26: t = "sizeof";
      27: t = "volatile";
      28: t = "do";
      29: t = "if";
      30: t = "static";
      31: t = "while";
      default: t = '0;
    endcase
    return t;
  endfunction

  // exact match on length and bytes; word_chars holds byte i at [8i+:8]
  function automatic logic [KIND_BITS-1:0] classify(input logic [WORD_DEPTH*8-1:0] chars,
                                                    input logic [LENGTH_BITS-1:0]  len);
    logic [KIND_BITS-1:0]    kind;
    logic [WORD_DEPTH*8-1:0] kw;
    logic                    same;
    int                      n;
    int                      idx;
    kind = KIND_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      kw = kw_text(k);
      n  = 0;
      for (int i = 0; i < WORD_DEPTH; i++) begin
        if (kw[8*i +: 8] != 8'h00) n = n + 1;
      end
      same = (len == LENGTH_BITS'(n));
      for (int i = 0; i < WORD_DEPTH; i++) begin
        idx = (i < n) ? (n - 1 - i) : 0;
        if (i < n && chars[8*i +: 8] != kw[8*idx +: 8]) same = 1'b0;
      end
      if (same) kind = KIND_FIRST_KW + KIND_BITS'(k);
    end
    return kind;
  endfunction

endpackage

// ===== hdl/keyword_identifier_tokenizer.sv =====
// keyword_identifier_tokenizer: top level of the keyword/identifier tokenizer
// instantiates kit_front, kit_fifo and kit_back; depends on kit_pkg
//
//  channel | ports                          | payload
//  --------+--------------------------------+---------------------------------
//  input   | in_valid, in_stall, in_data    | kit_in_t: char_code, end_of_input
//  output  | out_valid, out_stall, out_data | kit_tok_t: kind, row, col, ...
//
// one byte is accepted per cycle while the four-entry token queue has room
// a byte giving two tokens (word then error, or word then eof) sends both
// through the output register in turn; one giving none sends nothing out
// tokens leave through the token queue and then the output register
// reset is synchronous and needs no clearing pass; in_stall is queue full
module keyword_identifier_tokenizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kit_pkg::kit_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output kit_pkg::kit_tok_t out_data
);

  kit_pkg::kit_fifo_stat_t stat;
  kit_pkg::kit_entry_t     push_entry;
  kit_pkg::kit_entry_t     head_entry;
  logic                    push;
  logic                    pop;

  assign in_stall = stat.full;

  kit_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .stat     (stat),
    .push     (push),
    .entry    (push_entry)
  );

  kit_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_entry),
    .pop   (pop),
    .rdata (head_entry),
    .stat  (stat)
  );

  kit_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .entry     (head_entry),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // every end transfer queues an eof token
  a_end_pushes_eof: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.end_of_input) |->
      (push && push_entry.has_tok2 && !push_entry.tok2_err))
    else $error("end transfer did not queue an eof token");

  // a queued entry always carries at least one token
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_entry.has_word || push_entry.has_tok2))
    else $error("empty entry pushed into token queue");

  // queue cannot be full and empty at once
  a_fifo_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.full && stat.empty))
    else $error("token queue full and empty");

  // eof and error tokens close their run
  a_tok2_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.token_kind == kit_pkg::KIND_EOF ||
                   out_data.token_kind == kit_pkg::KIND_ERROR)) |->
      out_data.last_of_run)
    else $error("eof or error token without last_of_run");
`endif

endmodule

// ===== hdl/kit_front.sv =====
// kit_front: accepts source bytes, tracks position and the open word,
// and pushes token entries into the queue; depends on kit_pkg
module kit_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  kit_pkg::kit_in_t        in_data,
  input  kit_pkg::kit_fifo_stat_t stat,
  output logic                    push,
  output kit_pkg::kit_entry_t     entry
);

  localparam logic [kit_pkg::ROW_BITS-1:0]    ROW_MAX = '1;
  localparam logic [kit_pkg::COL_BITS-1:0]    COL_MAX = '1;
  localparam logic [kit_pkg::OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [kit_pkg::LENGTH_BITS-1:0] LEN_MAX = '1;

  logic                                in_word_r, in_word_nxt;
  logic [kit_pkg::WORD_DEPTH*8-1:0]    chars_r, chars_nxt;
  logic [kit_pkg::LENGTH_BITS-1:0]     len_r, len_nxt;
  logic [kit_pkg::ROW_BITS-1:0]        srow_r, srow_nxt;
  logic [kit_pkg::COL_BITS-1:0]        scol_r, scol_nxt;
  logic [kit_pkg::OFFSET_BITS-1:0]     soff_r, soff_nxt;
  logic [kit_pkg::ROW_BITS-1:0]        line_r, line_nxt;
  logic [kit_pkg::COL_BITS-1:0]        col_r, col_nxt;
  logic [kit_pkg::OFFSET_BITS-1:0]     off_r, off_nxt;

  logic [kit_pkg::ROW_BITS-1:0]        adv_line;
  logic [kit_pkg::COL_BITS-1:0]        adv_col;
  logic [kit_pkg::OFFSET_BITS-1:0]     adv_off;

  logic       acc;
  logic [7:0] c;
  logic       is_space, is_letter, is_word;

  assign acc = in_valid && !stat.full;
  assign c   = in_data.char_code;

  assign is_space  = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  assign is_letter = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  assign is_word   = is_letter || (c >= 8'h30 && c <= 8'h39) ||
                     (c == kit_pkg::CHAR_UNDERSCORE);

  // saturating position after consuming c
  always_comb begin
    adv_off  = (off_r != OFF_MAX) ? off_r + 1'b1 : off_r;
    adv_line = line_r;
    adv_col  = col_r;
    if (c == kit_pkg::CHAR_NEWLINE) begin
      adv_line = (line_r != ROW_MAX) ? line_r + 1'b1 : line_r;
      adv_col  = '0;
    end else if (col_r != COL_MAX) begin
      adv_col = col_r + 1'b1;
    end
  end

  always_comb begin
    in_word_nxt = in_word_r;
    chars_nxt   = chars_r;
    len_nxt     = len_r;
    srow_nxt    = srow_r;
    scol_nxt    = scol_r;
    soff_nxt    = soff_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    off_nxt     = off_r;
    push        = 1'b0;

    entry.has_word   = in_word_r;
    entry.word_chars = chars_r;
    entry.word_len   = len_r;
    entry.word_row   = srow_r;
    entry.word_col   = scol_r;
    entry.word_off   = soff_r;
    entry.has_tok2   = 1'b0;
    entry.tok2_err   = 1'b0;
    entry.tok2_row   = line_r;
    entry.tok2_col   = col_r;
    entry.tok2_off   = off_r;

    if (acc) begin
      if (in_data.end_of_input) begin
        entry.has_tok2 = 1'b1;
        push           = 1'b1;
        in_word_nxt    = 1'b0;
        line_nxt       = '0;
        col_nxt        = '0;
        off_nxt        = '0;
      end else if (in_word_r && is_word) begin
        entry.has_word = 1'b0;
        if (len_r < kit_pkg::LENGTH_BITS'(kit_pkg::WORD_DEPTH)) begin
          chars_nxt[{len_r[kit_pkg::WORD_IDX-1:0], 3'b000} +: 8] = c;
        end
        if (len_r != LEN_MAX) len_nxt = len_r + 1'b1;
        line_nxt = adv_line;
        col_nxt  = adv_col;
        off_nxt  = adv_off;
      end else begin
        line_nxt    = adv_line;
        col_nxt     = adv_col;
        off_nxt     = adv_off;
        in_word_nxt = 1'b0;
        push        = in_word_r;
        if (is_letter) begin
          in_word_nxt     = 1'b1;
          srow_nxt        = line_r;
          scol_nxt        = col_r;
          soff_nxt        = off_r;
          chars_nxt[7:0]  = c;
          len_nxt         = kit_pkg::LENGTH_BITS'(1);
        end else if (!is_space) begin
          entry.has_tok2 = 1'b1;
          entry.tok2_err = 1'b1;
          push           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_word_r <= 1'b0;
      len_r     <= '0;
      srow_r    <= '0;
      scol_r    <= '0;
      soff_r    <= '0;
      line_r    <= '0;
      col_r     <= '0;
      off_r     <= '0;
    end else begin
      in_word_r <= in_word_nxt;
      len_r     <= len_nxt;
      srow_r    <= srow_nxt;
      scol_r    <= scol_nxt;
      soff_r    <= soff_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
      off_r     <= off_nxt;
    end
  end

  // word bytes are only read below the current length
  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
  end

endmodule

// ===== hdl/kit_fifo.sv =====
// kit_fifo: short queue of token entries between front and back
// depends on kit_pkg
module kit_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  kit_pkg::kit_entry_t     wdata,
  input  logic                    pop,
  output kit_pkg::kit_entry_t     rdata,
  output kit_pkg::kit_fifo_stat_t stat
);

  kit_pkg::kit_entry_t           mem_r [kit_pkg::FIFO_DEPTH];
  logic [kit_pkg::FIFO_PTR-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [kit_pkg::FIFO_PTR-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [kit_pkg::FIFO_PTR:0]    count_r, count_nxt;
  logic                          do_push, do_pop;

  assign stat.full  = (count_r == (kit_pkg::FIFO_PTR+1)'(kit_pkg::FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

// ===== hdl/kit_back.sv =====
// kit_back: drains queue entries, matches keywords and drives the token
// output register, one token per cycle unless out_stall holds it; depends on kit_pkg
module kit_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  kit_pkg::kit_entry_t     entry,
  input  kit_pkg::kit_fifo_stat_t stat,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output kit_pkg::kit_tok_t       out_data
);

  logic              out_valid_r, out_valid_nxt;
  kit_pkg::kit_tok_t out_r, out_nxt;
  logic              phase_r, phase_nxt;
  logic              load;

  assign load      = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    pop           = 1'b0;
    phase_nxt     = phase_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load && !stat.empty) begin
      out_valid_nxt = 1'b1;
      if (!phase_r && entry.has_word) begin
        out_nxt.token_kind   = kit_pkg::classify(entry.word_chars, entry.word_len);
        out_nxt.token_row    = entry.word_row;
        out_nxt.token_col    = entry.word_col;
        out_nxt.token_offset = entry.word_off;
        out_nxt.token_length = entry.word_len;
        out_nxt.last_of_run  = !entry.has_tok2;
        // second token of the same entry follows next
        if (entry.has_tok2) phase_nxt = 1'b1;
        else pop = 1'b1;
      end else begin
        out_nxt.token_kind   = entry.tok2_err ? kit_pkg::KIND_ERROR : kit_pkg::KIND_EOF;
        out_nxt.token_row    = entry.tok2_row;
        out_nxt.token_col    = entry.tok2_col;
        out_nxt.token_offset = entry.tok2_off;
        out_nxt.token_length = entry.tok2_err ? kit_pkg::LENGTH_BITS'(1) : '0;
        out_nxt.last_of_run  = 1'b1;
        pop                  = 1'b1;
        phase_nxt            = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

// ===== tb/tb_keyword_identifier_tokenizer.sv =====
// tb_keyword_identifier_tokenizer: self-checking bench for the keyword/identifier tokenizer
// feeds source bytes and end items, predicts each token in-house and checks every token transfer
// depends on kit_pkg and keyword_identifier_tokenizer
module tb_keyword_identifier_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import kit_pkg::*;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  kit_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  kit_tok_t out_data;

  keyword_identifier_tokenizer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  string keyword_names [NUM_KW] = '{
    "auto", "double", "int", "struct", "break", "else", "long", "switch",
    "case", "enum", "register", "typedef", "char", "extern", "return", "union",
    "const", "float", "short", "unsigned", "continue", "for", "signed", "void",
    "default", "goto", "sizeof", "volatile", "do", "if", "static", "while"
  };

  kit_in_t  source_bytes[$];
  kit_tok_t expected_tokens[$];

  // lexer state as the block should hold it
  logic                   word_open  = 1'b0;
  logic [7:0]             word_bytes [WORD_DEPTH];
  logic [LENGTH_BITS-1:0] word_len   = '0;
  logic [ROW_BITS-1:0]    start_row  = '0;
  logic [COL_BITS-1:0]    start_col  = '0;
  logic [OFFSET_BITS-1:0] start_off  = '0;
  logic [ROW_BITS-1:0]    row_now    = '0;
  logic [COL_BITS-1:0]    col_now    = '0;
  logic [OFFSET_BITS-1:0] off_now    = '0;

  int mismatches  = 0;
  int items_taken = 0;
  int tokens_seen = 0;
  bit in_taken    = 1'b0;
  bit out_taken   = 1'b0;
  bit hold_off    = 1'b0;
  int send_wait   = 0;
  int recv_wait   = 0;
  int send_calm   = 0;
  int recv_calm   = 0;

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_word_byte(logic [7:0] c);
    return is_letter(c) || (c >= "0" && c <= "9") || c == CHAR_UNDERSCORE;
  endfunction

  function automatic void step_position(logic [7:0] c);
    if (off_now != '1) off_now = off_now + 1'b1;
    if (c == CHAR_NEWLINE) begin
      if (row_now != '1) row_now = row_now + 1'b1;
      col_now = '0;
    end else if (col_now != '1) begin
      col_now = col_now + 1'b1;
    end
  endfunction

  // exact match: the length must agree before any byte is compared
  function automatic logic [KIND_BITS-1:0] word_kind();
    logic [KIND_BITS-1:0] kind;
    bit                   same;
    kind = KIND_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (word_len == LENGTH_BITS'(keyword_names[k].len())) begin
        same = 1'b1;
        for (int i = 0; i < keyword_names[k].len(); i++) begin
          if (word_bytes[i] != keyword_names[k][i]) same = 1'b0;
        end
        if (same) kind = KIND_FIRST_KW + KIND_BITS'(k);
      end
    end
    return kind;
  endfunction

  function automatic kit_tok_t word_token(logic last);
    kit_tok_t t;
    t.token_kind   = word_kind();
    t.token_row    = start_row;
    t.token_col    = start_col;
    t.token_offset = start_off;
    t.token_length = word_len;
    t.last_of_run  = last;
    return t;
  endfunction

  function automatic void lex_item(kit_in_t item);
    logic [7:0] c;
    kit_tok_t   tok;
    c = item.char_code;
    if (item.end_of_input) begin
      if (word_open) expected_tokens.push_back(word_token(1'b0));
      tok = '{KIND_EOF, row_now, col_now, off_now, LENGTH_BITS'(0), 1'b1};
      expected_tokens.push_back(tok);
      row_now   = '0;
      col_now   = '0;
      off_now   = '0;
      word_open = 1'b0;
      return;
    end
    if (word_open && is_word_byte(c)) begin
      if (word_len < WORD_DEPTH) word_bytes[word_len[WORD_IDX-1:0]] = c;
      if (word_len != '1) word_len = word_len + 1'b1;
      step_position(c);
      return;
    end
    // closing byte: the word is last of run only if the byte makes no token
    if (word_open) begin
      expected_tokens.push_back(word_token(is_blank(c)));
      word_open = 1'b0;
    end
    if (is_letter(c)) begin
      word_open     = 1'b1;
      start_row     = row_now;
      start_col     = col_now;
      start_off     = off_now;
      word_bytes[0] = c;
      word_len      = LENGTH_BITS'(1);
    end else if (!is_blank(c)) begin
      tok = '{KIND_ERROR, row_now, col_now, off_now, LENGTH_BITS'(1), 1'b1};
      expected_tokens.push_back(tok);
    end
    step_position(c);
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 100) $display("%0t mismatch: %s", $time, what);
  endtask

  // wait cycles per transfer, with occasional calm stretches of no idling
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(15, 60);
    return $urandom_range(0, 6);
  endfunction

  function automatic void add_byte(logic [7:0] c);
    kit_in_t it;
    it.end_of_input = 1'b0;
    it.char_code    = c;
    source_bytes.push_back(it);
  endfunction

  function automatic void add_end(logic [7:0] c);
    kit_in_t it;
    it.end_of_input = 1'b1;
    it.char_code    = c;
    source_bytes.push_back(it);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] random_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] random_word_byte();
    int r;
    r = $urandom_range(0, 63);
    if (r < 52) return random_letter();
    if (r < 62) return 8'("0" + r - 52);
    return CHAR_UNDERSCORE;
  endfunction

  function automatic logic [7:0] random_blank();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? 8'h20 : 8'(r);
  endfunction

  function automatic logic [7:0] random_punct();
    string marks;
    marks = ";(){}[]+-*/=,<>#.&|!~%^:?";
    return marks[$urandom_range(0, marks.len() - 1)];
  endfunction

  // what follows a word decides how many tokens the closing byte gives
  function automatic void add_break();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: add_byte(random_blank());
      5, 6, 7:       add_byte(random_punct());
      8:             add_end(8'($urandom_range(0, 255)));
      default:       ;
    endcase
  endfunction

  // transfers are noted here; tokens are predicted and checked in order
  always @(posedge clk) begin
    kit_tok_t want;
    if (!rst_n) begin
      in_taken  = 1'b0;
      out_taken = 1'b0;
    end else begin
      in_taken  = in_valid && !in_stall;
      out_taken = out_valid && !out_stall;
      if (in_taken) begin
        lex_item(in_data);
        items_taken++;
      end
      if (out_taken) begin
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("token %0d with none pending: kind %0d offset %0d",
                                    tokens_seen, out_data.token_kind, out_data.token_offset));
        end else begin
          want = expected_tokens.pop_front();
          if (out_data.token_kind !== want.token_kind)
            report_mismatch($sformatf("token %0d kind: got %0d want %0d", tokens_seen,
                                      out_data.token_kind, want.token_kind));
          if (out_data.token_row !== want.token_row)
            report_mismatch($sformatf("token %0d row: got %0d want %0d", tokens_seen,
                                      out_data.token_row, want.token_row));
          if (out_data.token_col !== want.token_col)
            report_mismatch($sformatf("token %0d col: got %0d want %0d", tokens_seen,
                                      out_data.token_col, want.token_col));
          if (out_data.token_offset !== want.token_offset)
            report_mismatch($sformatf("token %0d offset: got %0d want %0d", tokens_seen,
                                      out_data.token_offset, want.token_offset));
          if (out_data.token_length !== want.token_length)
            report_mismatch($sformatf("token %0d length: got %0d want %0d", tokens_seen,
                                      out_data.token_length, want.token_length));
          if (out_data.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("token %0d last_of_run: got %0b want %0b", tokens_seen,
                                      out_data.last_of_run, want.last_of_run));
        end
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    logic    offer;
    kit_in_t next_item;
    offer     = in_valid;
    next_item = in_data;
    if (!rst_n) begin
      offer = 1'b0;
    end else begin
      if (in_taken) begin
        offer     = 1'b0;
        send_wait = hold_off ? 0 : draw_wait(send_calm);
      end
      if (!offer) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (source_bytes.size() != 0) begin
          next_item = source_bytes.pop_front();
          offer     = 1'b1;
        end
      end
    end
    in_valid <= offer;
    in_data  <= next_item;
  end

  // token receiver
  always @(negedge clk) begin
    if (out_taken) recv_wait = draw_wait(recv_calm);
    out_stall <= hold_off || recv_wait > 0;
    if (recv_wait > 0) recv_wait--;
  end

  // long receiver hold-offs so the token queue fills and the input stalls
  initial begin
    for (int n = 1; n <= 2; n++) begin
      while (items_taken < 500 * n) @(negedge clk);
      @(posedge clk);
      hold_off = 1'b1;
      repeat (80) @(posedge clk);
      hold_off = 1'b0;
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int    r;
    int    n;
    int    kw_turn;
    int    drain;
    string kw;

    add_text("int ");
    add_text("x_9@");
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(8'h80);
    add_byte(CHAR_UNDERSCORE);
    add_byte("7");
    add_byte(CHAR_NEWLINE);
    add_text("do");
    add_end(8'hff);
    add_text("autos\t");
    add_text("Z");
    add_byte(8'h0d);

    // random source text; keywords are taken in turn so each shows up
    kw_turn = 0;
    while (source_bytes.size() < 1380) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        kw = keyword_names[kw_turn % NUM_KW];
        kw_turn++;
        case ($urandom_range(0, 9))
          0: begin
            add_text(kw);
            add_byte(random_word_byte());
          end
          1: add_text(kw.substr(0, kw.len() - 2));
          2: begin
            kw.putc(0, kw[0] - 8'h20);
            add_text(kw);
          end
          default: add_text(kw);
        endcase
        add_break();
      end else if (r < 65) begin
        add_byte(random_letter());
        n = $urandom_range(0, 11);
        repeat (n) add_byte(random_word_byte());
        add_break();
      end else if (r < 80) begin
        add_byte(random_blank());
      end else if (r < 90) begin
        add_byte(random_punct());
      end else if (r < 97) begin
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_end(8'($urandom_range(0, 255)));
      end
    end
    add_end(8'($urandom_range(0, 255)));

    // one long word runs well past the kept bytes
    add_byte(random_letter());
    repeat (300) add_byte(random_word_byte());
    add_byte(8'h20);
    add_byte("@");
    add_end(8'h00);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (source_bytes.size() != 0 || in_valid) @(posedge clk);
    @(negedge clk);
    drain = 0;
    while (expected_tokens.size() != 0 && drain < 5000) begin
      @(negedge clk);
      drain++;
    end
    repeat (20) @(negedge clk);
    if (expected_tokens.size() != 0)
      report_mismatch($sformatf("%0d expected tokens never arrived", expected_tokens.size()));
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
